/* hdl/mbc_pkg.sv */
package mbc_pkg;

    // Field widths fixed by the item formats.
    localparam int POS_W = 13;
    localparam int VAL_W = 64;
    localparam int OPC_W = 4;
    localparam int ST_W  = 2;
    localparam int CNT_W = 4;
    localparam int SH_W  = 7;

    // Default store size and the depth of the command queue (a power of two).
    localparam int STORE_DEPTH_DEF = 4096;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam logic [POS_W-1:0] CAP_RESET  = 13'd4096;
    localparam logic [7:0]       GROUP_MASK = 8'h7F;
    localparam logic [7:0]       CONT_BIT   = 8'h80;
    localparam logic [7:0]       BYTE_MASK  = 8'hFF;

    // Byte counts of the fixed-width transfers.
    localparam logic [CNT_W-1:0] LEN_8  = 4'd1;
    localparam logic [CNT_W-1:0] LEN_32 = 4'd4;
    localparam logic [CNT_W-1:0] LEN_64 = 4'd8;

    // Shift steps per byte.
    localparam logic [SH_W-1:0] STEP_FIXED  = 7'd8;
    localparam logic [SH_W-1:0] STEP_VARINT = 7'd7;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR      = 4'd0,
        OP_SEEK       = 4'd1,
        OP_SKIP       = 4'd2,
        OP_PUT8       = 4'd3,
        OP_PUT32      = 4'd4,
        OP_PUT64      = 4'd5,
        OP_PUT_VARINT = 4'd6,
        OP_GET8       = 4'd7,
        OP_GET32      = 4'd8,
        OP_GET64      = 4'd9,
        OP_GET_VARINT = 4'd10
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_SEEK,
        CMD_SKIP,
        CMD_PUT,
        CMD_GET
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PUT,
        BK_GET
    } back_state_t;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [VAL_W-1:0] write_value;
        logic [POS_W-1:0] offset;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] read_value;
        logic [POS_W-1:0] cursor;
        logic [POS_W-1:0] used_length;
    } out_item_t;

    // Classified command passed from the front end to the executor.
    typedef struct packed {
        cmd_kind_t        kind;
        logic             varint;
        logic [CNT_W-1:0] nbytes;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] offset;
    } cmd_t;

    // Queue handshake driven by the executor.
    typedef struct packed {
        logic pop;
    } queue_ctrl_t;

endpackage

/* hdl/mbc_front.sv */
module mbc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mbc_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              push,
    output mbc_pkg::cmd_t     push_cmd
);
    import mbc_pkg::*;

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic [CNT_W-1:0] varint_len;

    // The held command moves on whenever the queue has room.
    assign push     = front_valid_reg && !q_full;
    assign in_stall = front_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push_cmd = cmd_reg;

    // Encoded length of a varint: one byte per started group of seven bits.
    always_comb
    begin
        varint_len = LEN_8;
        for (int k = 1; k < 10; k++)
        begin
            if (|(in_data.write_value >> (7 * k)))
            begin
                varint_len = CNT_W'(k + 1);
            end
        end
    end

    // Opcode decode.
    always_comb
    begin
        cmd_next.kind   = CMD_NOP;
        cmd_next.varint = 1'b0;
        cmd_next.nbytes = LEN_8;
        cmd_next.value  = in_data.write_value;
        cmd_next.offset = in_data.offset;
        unique case (in_data.opcode)
            OP_CLEAR:      cmd_next.kind = CMD_CLEAR;
            OP_SEEK:       cmd_next.kind = CMD_SEEK;
            OP_SKIP:       cmd_next.kind = CMD_SKIP;
            OP_PUT8:       cmd_next.kind = CMD_PUT;
            OP_PUT32:
            begin
                cmd_next.kind   = CMD_PUT;
                cmd_next.nbytes = LEN_32;
            end
            OP_PUT64:
            begin
                cmd_next.kind   = CMD_PUT;
                cmd_next.nbytes = LEN_64;
            end
            OP_PUT_VARINT:
            begin
                cmd_next.kind   = CMD_PUT;
                cmd_next.varint = 1'b1;
                cmd_next.nbytes = varint_len;
            end
            OP_GET8:       cmd_next.kind = CMD_GET;
            OP_GET32:
            begin
                cmd_next.kind   = CMD_GET;
                cmd_next.nbytes = LEN_32;
            end
            OP_GET64:
            begin
                cmd_next.kind   = CMD_GET;
                cmd_next.nbytes = LEN_64;
            end
            OP_GET_VARINT:
            begin
                cmd_next.kind   = CMD_GET;
                cmd_next.varint = 1'b1;
            end
            default:       cmd_next.kind = CMD_NOP;
        endcase
    end

    // Holding register occupancy.
    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* hdl/mbc_cmd_queue.sv */
module mbc_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output mbc_pkg::cmd_t pop_cmd
);
    import mbc_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = q_mem[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/mbc_back.sv */
module mbc_back #(
    parameter int STORE_DEPTH = mbc_pkg::STORE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [mbc_pkg::POS_W-1:0]    cfg_wr_data,
    input  logic                         cmd_valid,
    input  mbc_pkg::cmd_t                cmd,
    output mbc_pkg::queue_ctrl_t         q_ctrl,
    output logic                         out_valid,
    input  logic                         out_stall,
    output mbc_pkg::out_item_t           out_data
);
    import mbc_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam logic [POS_W:0] DEPTH_CAP = (STORE_DEPTH > int'(POS_MAX))
        ? (POS_W + 1)'(int'(POS_MAX) + 1) : (POS_W + 1)'(STORE_DEPTH);

    logic [7:0] mem [STORE_DEPTH];

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [POS_W-1:0] cap_reg;
    logic [POS_W-1:0] cursor_reg;
    logic [POS_W-1:0] cursor_next;
    logic [POS_W-1:0] used_reg;
    logic [POS_W-1:0] used_next;
    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;
    logic [SH_W-1:0]  sh_reg;
    logic [SH_W-1:0]  sh_next;
    logic             varint_reg;
    logic             varint_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;
    out_item_t        out_data_next;
    logic [7:0]       rdata_reg;

    logic [POS_W-1:0]  eff_cap;
    logic [POS_W:0]    nb_ext;
    logic [POS_W:0]    cursor_ext;
    logic [POS_W:0]    used_ext;
    logic [POS_W:0]    skip_sum;
    logic [POS_W:0]    cursor_inc;
    logic [POS_W-1:0]  avail;
    logic              room_ok;
    logic              data_ok;
    logic              slot_free;
    logic              load_out;
    logic [ST_W-1:0]   res_status;
    logic [VAL_W-1:0]  res_value;
    logic              wr_en;
    logic [7:0]        wr_byte;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        get_byte;
    logic [VAL_W-1:0]  get_val;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Capacity in force is the smaller of the register and the store size.
    assign eff_cap = ({1'b0, cap_reg} > DEPTH_CAP) ? DEPTH_CAP[POS_W-1:0] : cap_reg;

    // Space and data checks made when a command starts.
    assign nb_ext     = (POS_W + 1)'(cmd.nbytes);
    assign cursor_ext = {1'b0, cursor_reg};
    assign used_ext   = {1'b0, used_reg};
    assign room_ok    = (used_ext + nb_ext <= {1'b0, eff_cap})
                     && (cursor_ext + nb_ext <= {1'b0, eff_cap});
    assign avail      = used_reg - cursor_reg;
    assign data_ok    = (cursor_reg <= used_reg) && ({1'b0, avail} >= nb_ext);
    assign skip_sum   = cursor_ext + {1'b0, cmd.offset};
    assign cursor_inc = cursor_ext + 1'b1;

    // Byte arriving from the store, masked and placed at its bit position.
    assign get_byte = rdata_reg & (varint_reg ? GROUP_MASK : BYTE_MASK);
    assign get_val  = sh_reg[SH_W-1] ? val_reg
                    : (val_reg | ({{(VAL_W - 8){1'b0}}, get_byte} << sh_reg[SH_W-2:0]));

    // The result register is free if empty or emptied at this edge.
    assign slot_free = !out_valid_reg || !out_stall;

    // Next state, store access and result.
    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        used_next   = used_reg;
        val_next    = val_reg;
        remain_next = remain_reg;
        sh_next     = sh_reg;
        varint_next = varint_reg;
        q_ctrl.pop  = 1'b0;
        load_out    = 1'b0;
        res_status  = ST_OK;
        res_value   = '0;
        wr_en       = 1'b0;
        wr_byte     = val_reg[7:0];
        rd_addr     = ADDR_W'(cursor_reg);

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    q_ctrl.pop  = 1'b1;
                    varint_next = cmd.varint;
                    remain_next = cmd.nbytes;
                    val_next    = '0;
                    sh_next     = '0;
                    unique case (cmd.kind)
                        CMD_CLEAR:
                        begin
                            cursor_next = '0;
                            used_next   = '0;
                            load_out    = 1'b1;
                        end
                        CMD_SEEK:
                        begin
                            cursor_next = cmd.offset;
                            load_out    = 1'b1;
                        end
                        CMD_SKIP:
                        begin
                            cursor_next = skip_sum[POS_W] ? POS_MAX : skip_sum[POS_W-1:0];
                            load_out    = 1'b1;
                        end
                        CMD_PUT:
                        begin
                            if (room_ok)
                            begin
                                val_next   = cmd.value;
                                state_next = BK_PUT;
                            end
                            else
                            begin
                                res_status = ST_FULL;
                                load_out   = 1'b1;
                            end
                        end
                        CMD_GET:
                        begin
                            if (cmd.varint ? (cursor_reg < used_reg) : data_ok)
                            begin
                                state_next = BK_GET;
                            end
                            else
                            begin
                                res_status = ST_EMPTY;
                                load_out   = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            BK_PUT:
            begin
                // One byte per cycle at the cursor.
                wr_en       = 1'b1;
                cursor_next = cursor_inc[POS_W-1:0];
                remain_next = remain_reg - 1'b1;
                if (varint_reg)
                begin
                    wr_byte  = (val_reg[7:0] & GROUP_MASK)
                             | ((remain_reg != LEN_8) ? CONT_BIT : 8'h00);
                    val_next = val_reg >> 7;
                end
                else
                begin
                    wr_byte  = val_reg[7:0] & BYTE_MASK;
                    val_next = val_reg >> 8;
                end
                if (remain_reg == LEN_8)
                begin
                    used_next  = cursor_inc[POS_W-1:0];
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_GET:
            begin
                // Consume the byte read last cycle and fetch the one after it.
                rd_addr     = ADDR_W'(cursor_inc[POS_W-1:0]);
                cursor_next = cursor_inc[POS_W-1:0];
                remain_next = remain_reg - 1'b1;
                val_next    = get_val;
                if (!sh_reg[SH_W-1])
                begin
                    sh_next = sh_reg + (varint_reg ? STEP_VARINT : STEP_FIXED);
                end
                if (varint_reg)
                begin
                    if (!rdata_reg[7])
                    begin
                        res_value  = get_val;
                        load_out   = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else if (cursor_inc >= used_ext)
                    begin
                        // Ran out partway: the cursor stays past the bytes read.
                        res_status = ST_EMPTY;
                        load_out   = 1'b1;
                        state_next = BK_IDLE;
                    end
                end
                else if (remain_reg == LEN_8)
                begin
                    res_value  = get_val;
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next            = 1'b1;
            out_data_next.status      = res_status;
            out_data_next.read_value  = res_value;
            out_data_next.cursor      = cursor_next;
            out_data_next.used_length = used_next;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cap_reg       <= CAP_RESET;
            cursor_reg    <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        remain_reg   <= remain_next;
        sh_reg       <= sh_next;
        varint_reg   <= varint_next;
        out_data_reg <= out_data_next;
    end

    // Byte store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ADDR_W'(cursor_reg)] <= wr_byte;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

/* hdl/message_buffer_codec_unit.sv */
// Channel  | Signals                          | Beat taken when
// ---------+----------------------------------+-------------------------------
// input    | in_valid, in_stall, in_data      | in_valid high, in_stall low
// output   | out_valid, out_stall, out_data   | out_valid high, out_stall low
// config   | cfg_wr_en, cfg_wr_data           | cfg_wr_en high
//
// A beat passes a front register and a two-entry queue before the executor.
// The executor handles clear, seek, skip, unknown codes and failed checks in
// its idle state, and moves a put or get through its n bytes one at a time,
// since the byte store has one byte-wide port; a varint get runs per byte read.
// Reset clears cursor, used length and all handshake state; capacity goes
// to 4096. The store needs no clearing pass. A stalled result holds its beat
// while the front end keeps taking input until the queue fills.
module message_buffer_codec_unit #(
    parameter int STORE_DEPTH = mbc_pkg::STORE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  mbc_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output mbc_pkg::out_item_t        out_data,
    input  logic                      cfg_wr_en,
    input  logic [mbc_pkg::POS_W-1:0] cfg_wr_data
);
    import mbc_pkg::*;

    logic        push;
    cmd_t        push_cmd;
    logic        q_full;
    logic        q_valid;
    cmd_t        q_cmd;
    queue_ctrl_t q_ctrl;

    // Decode of incoming beats.
    mbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue between decode and execution.
    mbc_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_ctrl.pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    // Executor with the byte store.
    mbc_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (q_valid),
        .cmd         (q_cmd),
        .q_ctrl      (q_ctrl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

/* hdl/mbc_checker.sv */
module mbc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input mbc_pkg::out_item_t out_data
);
    import mbc_pkg::*;

    // A stalled result beat stays and holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    // Only the three defined status codes appear.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK) || (out_data.status == ST_FULL)
                      || (out_data.status == ST_EMPTY))
        else $error("undefined status code");

    // A failed operation returns no data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.read_value == '0)
        else $error("failed operation carries a value");

    // Both channels are quiet once reset has been held over a clock edge.
    a_reset_quiet: assert property (@(posedge clk)
        (!rst_n ##1 !rst_n) |-> !out_valid && !in_stall)
        else $error("handshake active during reset");

endmodule

bind message_buffer_codec_unit mbc_checker u_mbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
